// ===== rtl/core/mftt_pkg.sv =====
`default_nettype none
package mftt_pkg;

    localparam int ID_W      = 11;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int TURN_W    = 17;
    localparam int TOTAL_W   = 31;
    localparam int MIDX_W    = 3;
    localparam int TURN_SH   = 13;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 112;

    localparam logic [ID_W-1:0]          BASE_ID_RST = 11'h201;
    localparam logic signed [TURN_W-1:0] HALF_TURN   = 17'sd4095;
    localparam logic signed [TURN_W-1:0] TURNS_MAX   = 17'sd65535;
    localparam logic signed [TURN_W-1:0] TURNS_MIN   = -17'sd65536;

    typedef enum logic [0:0] {
        S_IDLE,
        S_CALC
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_mftt_cmd;

    typedef struct packed {
        logic match;
    } t_mftt_status;

endpackage
`default_nettype wire

// ===== rtl/core/motor_feedback_turn_tracker_top.sv =====
// Motor feedback turn tracker.
// Input stream (s_axis): one received feedback frame per word, identifier and
// seven payload bytes. Frames outside the MOTOR_COUNT identifiers starting at
// the base register (reset value 0x201) are dropped with no output word. The
// user must write it via i_cfg_we/i_cfg_wdata while idle; the block won't check.
// Output stream (m_axis): one word per matching frame with motor index, raw
// angle, speed, phase current, temperature, saturating turn count and unwrapped
// angle; tuser flags a first frame that only captured the offset.
// Each frame is handled in order: the idle state registers it and decodes the
// motor index, then the calc state does the read-modify-write of that motor's
// state. The block works on one frame at a time and takes no new frame before
// the last is finished; the result word is registered into the output register.
// The output register holds a finished word while m_axis_tready is low; the
// next frame is still taken and waits in the calc state until the output
// register frees. Reset clears all per-motor state and the offset flags.
`default_nettype none
module motor_feedback_turn_tracker_top
    import mftt_pkg::*;
#(
    parameter int MOTOR_COUNT = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [ID_W-1:0]     i_cfg_wdata,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // frame_id, data_byte0 .. data_byte6, zero pad
    input  wire  [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // motor_index, rotor_angle, rotor_speed, phase_current, temperature,
    // turn_count, unwrapped_angle, zero pad
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // first_frame
    output logic                m_axis_tuser
);

    t_mftt_cmd    cmd;
    t_mftt_status status;

    mftt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mftt_datapath #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (m_axis_tdata),
        .o_out_first (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mftt_ctrl.sv =====
`default_nettype none
module mftt_ctrl
    import mftt_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire          i_out_ready,
    output logic         o_out_valid,
    input  t_mftt_status i_status,
    output t_mftt_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CALC;
                end
            end
            S_CALC: begin
                if (!i_status.match) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/core/mftt_datapath.sv =====
`default_nettype none
module mftt_datapath
    import mftt_pkg::*;
#(
    parameter int MOTOR_COUNT = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [ID_W-1:0]     i_cfg_wdata,
    input  wire  [S_DATA_W-1:0] i_in_data,
    input  t_mftt_cmd           i_cmd,
    output t_mftt_status        o_status,
    output logic [M_DATA_W-1:0] o_out_data,
    output logic                o_out_first
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    logic [ID_W-1:0]   r_base;
    logic              r_match;
    logic [IDX_W-1:0]  r_idx;
    logic [WORD_W-1:0] r_raw, r_speed_in, r_cur_in;
    logic [BYTE_W-1:0] r_temp_in;

    logic                      r_seen   [MOTOR_COUNT];
    logic [WORD_W-1:0]         r_offset [MOTOR_COUNT];
    logic [WORD_W-1:0]         r_angle  [MOTOR_COUNT];
    logic [WORD_W-1:0]         r_speed  [MOTOR_COUNT];
    logic [WORD_W-1:0]         r_cur    [MOTOR_COUNT];
    logic [BYTE_W-1:0]         r_temp   [MOTOR_COUNT];
    logic signed [TURN_W-1:0]  r_turns  [MOTOR_COUNT];
    logic signed [TOTAL_W-1:0] r_total  [MOTOR_COUNT];

    logic [ID_W:0]             id_diff;
    logic [ID_W-1:0]           in_id;
    logic                      first;
    logic [WORD_W-1:0]         ang_old, off_cur;
    logic signed [TURN_W-1:0]  delta, turns_old;
    logic [WORD_W-1:0]         n_speed, n_cur;
    logic [BYTE_W-1:0]         n_temp;
    logic signed [TURN_W-1:0]  n_turns;
    logic signed [TOTAL_W-1:0] n_total;

    assign in_id   = i_in_data[10:0];
    assign id_diff = {1'b0, in_id} - {1'b0, r_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_ID_RST;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_cmd.capture) begin
            r_match <= !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(MOTOR_COUNT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx      <= id_diff[IDX_W-1:0];
            r_raw      <= {i_in_data[18:11], i_in_data[26:19]};
            r_speed_in <= {i_in_data[34:27], i_in_data[42:35]};
            r_cur_in   <= {i_in_data[50:43], i_in_data[58:51]};
            r_temp_in  <= i_in_data[66:59];
        end
    end

    assign o_status.match = r_match;

    assign first     = !r_seen[r_idx];
    assign ang_old   = r_angle[r_idx];
    assign turns_old = r_turns[r_idx];
    assign off_cur   = first ? r_raw : r_offset[r_idx];
    assign delta     = $signed({1'b0, r_raw}) - $signed({1'b0, ang_old});

    always_comb begin
        n_speed = first ? r_speed[r_idx] : r_speed_in;
        n_cur   = first ? r_cur[r_idx] : r_cur_in;
        n_temp  = first ? r_temp[r_idx] : r_temp_in;
        n_turns = turns_old;
        if (!first) begin
            if (delta > HALF_TURN) begin
                if (turns_old != TURNS_MIN) begin
                    n_turns = turns_old - 17'sd1;
                end
            end else if (delta < -HALF_TURN) begin
                if (turns_old != TURNS_MAX) begin
                    n_turns = turns_old + 17'sd1;
                end
            end
        end
        if (first) begin
            n_total = r_total[r_idx];
        end else begin
            n_total = $signed({n_turns[TURN_W-1], n_turns, {TURN_SH{1'b0}}})
                    + $signed({15'd0, r_raw}) - $signed({15'd0, off_cur});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_seen[i]   <= 1'b0;
                r_offset[i] <= '0;
                r_angle[i]  <= '0;
                r_speed[i]  <= '0;
                r_cur[i]    <= '0;
                r_temp[i]   <= '0;
                r_turns[i]  <= '0;
                r_total[i]  <= '0;
            end
        end else if (i_cmd.commit) begin
            r_seen[r_idx]   <= 1'b1;
            r_offset[r_idx] <= off_cur;
            r_angle[r_idx]  <= r_raw;
            r_speed[r_idx]  <= n_speed;
            r_cur[r_idx]    <= n_cur;
            r_temp[r_idx]   <= n_temp;
            r_turns[r_idx]  <= n_turns;
            r_total[r_idx]  <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_first <= first;
            o_out_data  <= {5'd0, n_total, n_turns, n_temp, n_cur, n_speed, r_raw,
                            MIDX_W'(r_idx)};
        end
    end

endmodule
`default_nettype wire
